// File: sv/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

    // Field and register widths.
    localparam int ELEM_W = 16;
    localparam int TOL_W  = 14;

    // Fixed-point constants in raw units.
    localparam int ONE_Q14_W = 19;
    localparam logic signed [ONE_Q14_W-1:0] ONE_Q14 = 19'sd16384;
    localparam int DET_W = 52;
    localparam logic signed [DET_W-1:0] ONE_Q42 = 52'sd4398046511104;
    localparam int TOL_SHIFT = 28;

    // Square root: radicand in Q.14 shifted up by 28 bits gives a root in Q.21.
    localparam int RAD_W     = 17;
    localparam int RAD_SHIFT = 28;
    localparam int SQ_N_W    = RAD_W + RAD_SHIFT;
    localparam int SQ_W      = (SQ_N_W + 1) / 2;
    localparam int SQ_T_W    = SQ_N_W + 3;

    // Off-diagonal quotient (2*|d|*2^20 + q) / (2*q).
    localparam int D_W        = 17;
    localparam int NUM_W      = 38;
    localparam int DEN_W      = SQ_W + 1;
    localparam int QUO_W      = 16;
    localparam int DV_CMP_W   = DEN_W + QUO_W + 1;
    localparam int DIV_STAGES = QUO_W + 1;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    // Data that rides alongside the square root.
    typedef struct packed {
        logic                  accept;
        t_branch               branch;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
    } t_sq_side;

endpackage
`default_nettype wire

// File: sv/rmq_mat_if.sv
`default_nettype none
interface rmq_mat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r0c0;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r0c1;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r0c2;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r1c0;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r1c1;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r1c2;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r2c0;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r2c1;
    logic signed [rmq_pkg::ELEM_W-1:0]    elem_r2c2;

    modport source (
        output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        input  ready
    );
    modport sink (
        input  valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/rmq_quat_if.sv
`default_nettype none
interface rmq_quat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::ELEM_W-1:0]    quat_x;
    logic signed [rmq_pkg::ELEM_W-1:0]    quat_y;
    logic signed [rmq_pkg::ELEM_W-1:0]    quat_z;
    logic signed [rmq_pkg::ELEM_W-1:0]    quat_w;
    logic                                 accepted;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, accepted,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, accepted,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/rmq_sqrt.sv
`default_nettype none
// Pipelined integer square root of rad * 2^28, one root bit per stage.
module rmq_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [rmq_pkg::RAD_W-1:0]     i_rad,
    input  wire rmq_pkg::t_sq_side             i_side,
    output logic                               o_vld,
    output logic [rmq_pkg::SQ_W-1:0]           o_root,
    output rmq_pkg::t_sq_side                  o_side
);
    localparam int NS = rmq_pkg::SQ_W;

    logic                            r_vld  [0:NS-1];
    logic [rmq_pkg::SQ_N_W-1:0]      r_rem  [0:NS-1];
    logic [NS-1:0]                   r_res  [0:NS-1];
    rmq_pkg::t_sq_side               r_side [0:NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int B = NS - 1 - j;
        logic [rmq_pkg::SQ_N_W-1:0] rem_in;
        logic [NS-1:0]              res_in;
        logic                       vld_in;
        rmq_pkg::t_sq_side          side_in;
        logic [rmq_pkg::SQ_T_W-1:0] trial;
        logic [rmq_pkg::SQ_N_W-1:0] n_rem;
        logic [NS-1:0]              n_res;

        if (j == 0) begin : g_first
            assign rem_in  = {i_rad, {rmq_pkg::RAD_SHIFT{1'b0}}};
            assign res_in  = '0;
            assign vld_in  = i_vld;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign res_in  = r_res[j-1];
            assign vld_in  = r_vld[j-1];
            assign side_in = r_side[j-1];
        end

        assign trial = (rmq_pkg::SQ_T_W'(res_in) << (B + 1))
                     + (rmq_pkg::SQ_T_W'(1) << (2 * B));

        always_comb begin
            if (rmq_pkg::SQ_T_W'(rem_in) >= trial) begin
                n_rem = rem_in - trial[rmq_pkg::SQ_N_W-1:0];
                n_res = res_in | (NS'(1) << B);
            end else begin
                n_rem = rem_in;
                n_res = res_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_res[j]  <= n_res;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_res[NS-1];
    assign o_side = r_side[NS-1];
endmodule
`default_nettype wire

// File: sv/rmq_div.sv
`default_nettype none
// Pipelined restoring divider: one overflow check, then one quotient bit per stage.
module rmq_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [rmq_pkg::NUM_W-1:0]     i_num,
    input  wire logic [rmq_pkg::DEN_W-1:0]     i_den,
    output logic [rmq_pkg::QUO_W-1:0]          o_quo,
    output logic                               o_ovf
);
    localparam int NS = rmq_pkg::DIV_STAGES;
    localparam int CW = rmq_pkg::DV_CMP_W;

    logic [rmq_pkg::NUM_W-1:0] r_rem [0:NS-1];
    logic [rmq_pkg::DEN_W-1:0] r_den [0:NS-1];
    logic [rmq_pkg::QUO_W-1:0] r_quo [0:NS-1];
    logic                      r_ovf [0:NS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << rmq_pkg::QUO_W);
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;
        logic [CW-1:0]             shifted;
        logic [rmq_pkg::NUM_W-1:0] n_rem;
        logic [rmq_pkg::QUO_W-1:0] n_quo;

        assign shifted = CW'(r_den[j-1]) << K;

        always_comb begin
            if (CW'(r_rem[j-1]) >= shifted) begin
                n_rem = r_rem[j-1] - shifted[rmq_pkg::NUM_W-1:0];
                n_quo = r_quo[j-1] | (rmq_pkg::QUO_W'(1) << K);
            end else begin
                n_rem = r_rem[j-1];
                n_quo = r_quo[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_den[j] <= r_den[j-1];
                r_quo[j] <= n_quo;
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_ovf = r_ovf[NS-1];
endmodule
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion.sv
`default_nettype none
// Rotation matrix to unit quaternion converter (Shepperd's method), fully
// pipelined. A 3x3 matrix in signed Q1.14 is taken in one transfer on i_mat
// and one result transfer on o_quat follows for every matrix, in order. A new
// matrix can be taken in every cycle in which the pipeline advances. It has
// five stages for the exact determinant check, 23 stages of the bit-per-stage
// square root, one stage to form the numerators, 17 stages of the three
// parallel bit-per-stage dividers and the output register. The whole pipeline
// advances whenever the output register is empty or its result is being taken,
// so a stall on o_quat freezes every stage and nothing is lost or repeated. The
// matrix is accepted only if its determinant lies within det_tolerance Q1.14
// units of one; otherwise the result carries zero components and accepted low.
// det_tolerance is written through i_cfg_we and i_cfg_wdata, and should only
// be changed while no matrix is in flight.
module rotation_matrix_to_quaternion (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rmq_pkg::TOL_W-1:0]     i_cfg_wdata,
    rmq_mat_if.sink                            i_mat,
    rmq_quat_if.source                         o_quat
);
    localparam int EW = rmq_pkg::ELEM_W;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int TW = CW + EW;
    localparam int DW = rmq_pkg::D_W;

    // Data carried alongside the determinant stages.
    typedef struct packed {
        logic [rmq_pkg::RAD_W-1:0] rad;
        rmq_pkg::t_sq_side         side;
    } t_carry;

    // Data carried alongside the dividers.
    typedef struct packed {
        logic                   accept;
        rmq_pkg::t_branch       branch;
        logic signed [EW-1:0]   diag;
        logic                   neg0;
        logic                   neg1;
        logic                   neg2;
    } t_dv_side;

    logic en;
    logic [rmq_pkg::TOL_W-1:0] r_det_tol;

    // The pipeline moves as one; the output register parts it from the sink.
    assign en          = !o_quat.valid || o_quat.ready;
    assign i_mat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_tol <= '0;
        end else if (i_cfg_we) begin
            r_det_tol <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the six two-by-two products, branch choice and radicand.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [17:0]   trace;
    logic signed [rmq_pkg::ONE_Q14_W-1:0] rad_raw;
    t_carry n1_carry;

    assign m00 = i_mat.elem_r0c0;
    assign m01 = i_mat.elem_r0c1;
    assign m02 = i_mat.elem_r0c2;
    assign m10 = i_mat.elem_r1c0;
    assign m11 = i_mat.elem_r1c1;
    assign m12 = i_mat.elem_r1c2;
    assign m20 = i_mat.elem_r2c0;
    assign m21 = i_mat.elem_r2c1;
    assign m22 = i_mat.elem_r2c2;

    assign trace = 18'(m00) + 18'(m11) + 18'(m22);

    // Branch and the signed off-diagonal sums feeding the three dividers.
    always_comb begin
        n1_carry.side.accept = 1'b0;
        if (trace > 18'sd0) begin
            n1_carry.side.branch = rmq_pkg::BR_W;
            rad_raw = 19'(trace) + rmq_pkg::ONE_Q14;
            n1_carry.side.d0 = DW'(m21) - DW'(m12);
            n1_carry.side.d1 = DW'(m02) - DW'(m20);
            n1_carry.side.d2 = DW'(m10) - DW'(m01);
        end else if (m00 > m11 && m00 > m22) begin
            n1_carry.side.branch = rmq_pkg::BR_X;
            rad_raw = 19'(m00) - 19'(m11) - 19'(m22) + rmq_pkg::ONE_Q14;
            n1_carry.side.d0 = DW'(m10) + DW'(m01);
            n1_carry.side.d1 = DW'(m02) + DW'(m20);
            n1_carry.side.d2 = DW'(m21) - DW'(m12);
        end else if (m11 > m22) begin
            n1_carry.side.branch = rmq_pkg::BR_Y;
            rad_raw = 19'(m11) - 19'(m00) - 19'(m22) + rmq_pkg::ONE_Q14;
            n1_carry.side.d0 = DW'(m10) + DW'(m01);
            n1_carry.side.d1 = DW'(m21) + DW'(m12);
            n1_carry.side.d2 = DW'(m02) - DW'(m20);
        end else begin
            n1_carry.side.branch = rmq_pkg::BR_Z;
            rad_raw = 19'(m22) - 19'(m00) - 19'(m11) + rmq_pkg::ONE_Q14;
            n1_carry.side.d0 = DW'(m02) + DW'(m20);
            n1_carry.side.d1 = DW'(m21) + DW'(m12);
            n1_carry.side.d2 = DW'(m10) - DW'(m01);
        end
        // A radicand below one LSB only arises for matrices that are not
        // rotations; it is raised to one LSB to keep the reciprocal finite.
        if (rad_raw < 19'sd1) begin
            n1_carry.rad = rmq_pkg::RAD_W'(1);
        end else begin
            n1_carry.rad = rad_raw[rmq_pkg::RAD_W-1:0];
        end
    end

    logic                 r_vld   [0:4];
    t_carry               r_carry [0:4];
    t_carry               n5_carry;
    logic signed [PW-1:0] r1_p1122, r1_p1221, r1_p1022, r1_p1220, r1_p1021, r1_p1120;
    logic signed [EW-1:0] r1_m00, r1_m01, r1_m02;
    logic signed [CW-1:0] r2_c0, r2_c1, r2_c2;
    logic signed [EW-1:0] r2_m00, r2_m01, r2_m02;
    logic signed [TW-1:0] r3_t0, r3_t1, r3_t2;
    logic signed [rmq_pkg::DET_W-1:0] r4_dev;
    logic [rmq_pkg::DET_W-1:0]        abs_dev;
    logic                             tol_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_mat.valid;
            for (int k = 1; k < 5; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 5 compare: |det - 1| against the tolerance, both in Q.42.
    assign abs_dev = (r4_dev < 0) ? $unsigned(-r4_dev) : $unsigned(r4_dev);
    assign tol_ok  = abs_dev <= (rmq_pkg::DET_W'(r_det_tol) << rmq_pkg::TOL_SHIFT);

    // The verdict joins the carried data on its way into stage 5.
    always_comb begin
        n5_carry             = r_carry[3];
        n5_carry.side.accept = tol_ok;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1
            r_carry[0] <= n1_carry;
            r1_p1122 <= m11 * m22;
            r1_p1221 <= m12 * m21;
            r1_p1022 <= m10 * m22;
            r1_p1220 <= m12 * m20;
            r1_p1021 <= m10 * m21;
            r1_p1120 <= m11 * m20;
            r1_m00 <= m00;
            r1_m01 <= m01;
            r1_m02 <= m02;
            // Stage 2: cofactors.
            r_carry[1] <= r_carry[0];
            r2_c0 <= CW'(r1_p1122) - CW'(r1_p1221);
            r2_c1 <= CW'(r1_p1022) - CW'(r1_p1220);
            r2_c2 <= CW'(r1_p1021) - CW'(r1_p1120);
            r2_m00 <= r1_m00;
            r2_m01 <= r1_m01;
            r2_m02 <= r1_m02;
            // Stage 3: first-row terms.
            r_carry[2] <= r_carry[1];
            r3_t0 <= TW'(r2_m00) * TW'(r2_c0);
            r3_t1 <= TW'(r2_m01) * TW'(r2_c1);
            r3_t2 <= TW'(r2_m02) * TW'(r2_c2);
            // Stage 4: determinant minus one.
            r_carry[3] <= r_carry[2];
            r4_dev <= rmq_pkg::DET_W'(r3_t0) - rmq_pkg::DET_W'(r3_t1)
                    + rmq_pkg::DET_W'(r3_t2) - rmq_pkg::ONE_Q42;
            // Stage 5: tolerance check.
            r_carry[4] <= n5_carry;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the radicand, giving q in Q.21.
    // ------------------------------------------------------------------
    logic                        sq_vld;
    logic [rmq_pkg::SQ_W-1:0]    sq_root;
    rmq_pkg::t_sq_side           sq_side;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[4]),
        .i_rad   (r_carry[4].rad),
        .i_side  (r_carry[4].side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage after the root: the diagonal part, rounded half up, and the
    // numerators 2*|d|*2^20 + q over the common divisor 2*q, which gives
    // |d|/(2 sqrt(rad)) rounded to nearest with ties away from zero.
    // ------------------------------------------------------------------
    logic [rmq_pkg::SQ_W:0]    diag_sum;
    logic [rmq_pkg::SQ_W-8:0]  diag_sh;
    logic signed [EW-1:0]      diag_sat;
    logic [DW-1:0]             mag0, mag1, mag2;

    assign diag_sum = (rmq_pkg::SQ_W+1)'(sq_root) + (rmq_pkg::SQ_W+1)'(128);
    assign diag_sh  = diag_sum[rmq_pkg::SQ_W:8];
    assign diag_sat = (diag_sh > (rmq_pkg::SQ_W-7)'(32767)) ? 16'sd32767
                                                             : diag_sh[EW-1:0];

    assign mag0 = sq_side.d0[DW-1] ? DW'(-sq_side.d0) : DW'(sq_side.d0);
    assign mag1 = sq_side.d1[DW-1] ? DW'(-sq_side.d1) : DW'(sq_side.d1);
    assign mag2 = sq_side.d2[DW-1] ? DW'(-sq_side.d2) : DW'(sq_side.d2);

    logic                         r6_vld;
    t_dv_side                     r6_side;
    logic [rmq_pkg::NUM_W-1:0]    r6_num0, r6_num1, r6_num2;
    logic [rmq_pkg::DEN_W-1:0]    r6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side.accept <= sq_side.accept;
            r6_side.branch <= sq_side.branch;
            r6_side.diag   <= diag_sat;
            r6_side.neg0   <= sq_side.d0[DW-1];
            r6_side.neg1   <= sq_side.d1[DW-1];
            r6_side.neg2   <= sq_side.d2[DW-1];
            r6_num0 <= (rmq_pkg::NUM_W'(mag0) << 21) + rmq_pkg::NUM_W'(sq_root);
            r6_num1 <= (rmq_pkg::NUM_W'(mag1) << 21) + rmq_pkg::NUM_W'(sq_root);
            r6_num2 <= (rmq_pkg::NUM_W'(mag2) << 21) + rmq_pkg::NUM_W'(sq_root);
            r6_den  <= {sq_root, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Three dividers in parallel with a matching delay line for the rest.
    // ------------------------------------------------------------------
    logic [rmq_pkg::QUO_W-1:0] quo0, quo1, quo2;
    logic                      ovf0, ovf1, ovf2;

    rmq_div u_div0 (
        .i_clk (i_clk), .i_en (en), .i_num (r6_num0), .i_den (r6_den),
        .o_quo (quo0), .o_ovf (ovf0)
    );
    rmq_div u_div1 (
        .i_clk (i_clk), .i_en (en), .i_num (r6_num1), .i_den (r6_den),
        .o_quo (quo1), .o_ovf (ovf1)
    );
    rmq_div u_div2 (
        .i_clk (i_clk), .i_en (en), .i_num (r6_num2), .i_den (r6_den),
        .o_quo (quo2), .o_ovf (ovf2)
    );

    localparam int NDV = rmq_pkg::DIV_STAGES;
    logic     r_dv_vld  [0:NDV-1];
    t_dv_side r_dv_side [0:NDV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDV; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_vld[0] <= r6_vld;
            for (int k = 1; k < NDV; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r6_side;
            for (int k = 1; k < NDV; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation, placement by branch and zeroing of rejected results.
    // A quotient of 2^15 or more saturates either way.
    // ------------------------------------------------------------------
    t_dv_side             fin;
    logic signed [EW-1:0] off0, off1, off2;
    logic signed [EW-1:0] n_x, n_y, n_z, n_w;

    assign fin = r_dv_side[NDV-1];

    function automatic logic signed [15:0] sat_part(
        input logic                     neg,
        input logic [15:0]              quo,
        input logic                     ovf
    );
        logic big;
        big = ovf || quo[15];
        if (neg) begin
            sat_part = big ? -16'sd32768 : -$signed(quo);
        end else begin
            sat_part = big ? 16'sd32767 : $signed(quo);
        end
    endfunction

    assign off0 = sat_part(fin.neg0, quo0, ovf0);
    assign off1 = sat_part(fin.neg1, quo1, ovf1);
    assign off2 = sat_part(fin.neg2, quo2, ovf2);

    always_comb begin
        case (fin.branch)
            rmq_pkg::BR_W: begin
                n_x = off0;     n_y = off1;     n_z = off2;     n_w = fin.diag;
            end
            rmq_pkg::BR_X: begin
                n_x = fin.diag; n_y = off0;     n_z = off1;     n_w = off2;
            end
            rmq_pkg::BR_Y: begin
                n_x = off0;     n_y = fin.diag; n_z = off1;     n_w = off2;
            end
            default: begin
                n_x = off0;     n_y = off1;     n_z = fin.diag; n_w = off2;
            end
        endcase
        if (!fin.accept) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
            n_w = '0;
        end
    end

    logic                 r_out_vld;
    logic signed [EW-1:0] r_out_x, r_out_y, r_out_z, r_out_w;
    logic                 r_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[NDV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= n_x;
            r_out_y   <= n_y;
            r_out_z   <= n_z;
            r_out_w   <= n_w;
            r_out_acc <= fin.accept;
        end
    end

    assign o_quat.valid    = r_out_vld;
    assign o_quat.quat_x   = r_out_x;
    assign o_quat.quat_y   = r_out_y;
    assign o_quat.quat_z   = r_out_z;
    assign o_quat.quat_w   = r_out_w;
    assign o_quat.accepted = r_out_acc;
endmodule
`default_nettype wire
